FILE: rtl/core/square_transposition_cipher_assert.svh
// Assertion macros for the square transposition cipher RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef SQUARE_TRANSPOSITION_CIPHER_ASSERT_SVH
`define SQUARE_TRANSPOSITION_CIPHER_ASSERT_SVH
`ifndef ASSERT_OFF
// Property checked on every rising clock edge outside reset.
`define STC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition that must never be true outside reset.
`define STC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define STC_ASSERT(lbl, clk, rstn, prop, msg)
`define STC_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

FILE: rtl/core/stc_pkg.sv
// Shared types and constants of the square transposition cipher.
// No dependencies; imported by stc_ctrl, the top level and the testbench.
package stc_pkg;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] FMT_CIPHER  = 2'd0;
  localparam logic [1:0] FMT_GROUPED = 2'd1;
  localparam logic [1:0] FMT_ROWS    = 2'd2;

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam int unsigned SIDE_LEN_W = 6;

  typedef enum logic {
    ST_IDLE,
    ST_FETCH
  } stc_state_e;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_SPACE,
    SRC_MEM
  } stc_src_e;

  typedef struct packed {
    stc_src_e              char_src;
    logic                  group_end;
    logic                  last;
    logic                  none_left;
    logic [SIDE_LEN_W-1:0] side_length;
    logic                  overflowed;
  } stc_res_t;

endpackage

FILE: rtl/core/square_transposition_cipher.sv
// Top level of the square transposition cipher: control, character store and output register.
// Depends on stc_pkg, stc_ctrl, stc_char_mem and the assertion macro header.
//
// Usage. Items enter on the input channel (in_valid_i, in_stall_o, mode_i, data_byte_i).
// A write item appends a letter or digit, folded to lower case, to the character store;
// other bytes only restart the read cursor. A clear item empties the store. A read item
// returns one output character on the result channel (out_valid_o, out_stall_i and the
// payload ports), in the order chosen by output_format_i, which the user writes through
// output_format_we_i only while idle; not enforced. Writes and clears cause no result.
// Timing. A write or clear item is taken while the control is idle. For a read item the cursor
// address goes to the character store at acceptance; the store's registered read data then
// joins the result in the fetch state, after which the item lands in the output register.
// No input item is accepted while a read waits in the fetch state.
// Stalls. The output register holds a finished item while out_stall_i is high; the next
// input item is still accepted, and a following read waits in the control only when the
// output register is still occupied.
// Reset. The counters, the side, the cursor and the format clear at once; the store has
// no clearing pass, since only entries below the fill count are ever used.
`include "square_transposition_cipher_assert.svh"
module square_transposition_cipher #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       output_format_we_i,
  input  logic [1:0] output_format_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       group_end_o,
  output logic       last_o,
  output logic       none_left_o,
  output logic [5:0] side_length_o,
  output logic       overflowed_o
);
  import stc_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);

  logic          res_valid, res_take;
  stc_res_t      res;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;
  logic [7:0]    char_sel;

  logic       out_valid_q, out_valid_d;
  logic [7:0] char_q;
  logic       group_end_q, last_q, none_left_q, overflowed_q;
  logic [5:0] side_q;

  stc_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (output_format_we_i),
    .cfg_wdata_i (output_format_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .data_byte_i (data_byte_i),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr)
  );

  stc_char_mem #(
    .DEPTH(CAPACITY)
  ) u_char_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // The finished item moves into the output register when that register is free or
  // being emptied in the same cycle.
  assign res_take    = res_valid && (!out_valid_q || !out_stall_i);
  assign out_valid_d = res_take || (out_valid_q && out_stall_i);

  always_comb begin
    unique case (res.char_src)
      SRC_MEM:   char_sel = mem_rdata;
      SRC_SPACE: char_sel = SPACE_CHAR;
      default:   char_sel = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      char_q       <= char_sel;
      group_end_q  <= res.group_end;
      last_q       <= res.last;
      none_left_q  <= res.none_left;
      side_q       <= res.side_length;
      overflowed_q <= res.overflowed;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = char_q;
  assign group_end_o   = group_end_q;
  assign last_o        = last_q;
  assign none_left_o   = none_left_q;
  assign side_length_o = side_q;
  assign overflowed_o  = overflowed_q;

  `STC_ASSERT(a_none_is_empty, clk_i, rst_ni,
              (out_valid_o && none_left_o) |->
              ((out_char_o == 8'h00) && !last_o && !group_end_o),
              "exhausted item carries data")
  `STC_ASSERT(a_last_ends_group, clk_i, rst_ni, (out_valid_o && last_o) |-> group_end_o,
              "last without group end")
  `STC_ASSERT(a_take_loads, clk_i, rst_ni, res_take |=> out_valid_o, "taken item not presented")

endmodule

FILE: rtl/core/stc_char_mem.sv
// Character store: one write port and one read port with registered read data.
// No dependencies.
module stc_char_mem #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/stc_ctrl.sv
// Control of the square transposition cipher: counters, side, read cursor and sequencer.
// Depends on stc_pkg and the assertion macro header.
`include "square_transposition_cipher_assert.svh"
module stc_ctrl #(
  parameter int unsigned CAPACITY = 1024,
  localparam int unsigned AW = $clog2(CAPACITY)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       mode_i,
  input  logic [7:0]       data_byte_i,
  output logic             res_valid_o,
  input  logic             res_take_i,
  output stc_pkg::stc_res_t res_o,
  output logic             mem_we_o,
  output logic [AW-1:0]    mem_waddr_o,
  output logic [7:0]       mem_wdata_o,
  output logic             mem_re_o,
  output logic [AW-1:0]    mem_raddr_o
);
  import stc_pkg::*;

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned SIDE_W = ($clog2(CAPACITY) + 1) / 2 + 1;
  localparam int unsigned IDX_W  = 2 * SIDE_W;

  stc_state_e        state_q, state_d;
  logic [1:0]        fmt_q, fmt_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SIDE_W-1:0] side_q, side_d;
  logic [SIDE_W-1:0] major_q, major_d;
  logic [SIDE_W-1:0] minor_q, minor_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              sep_q, sep_d;
  logic              ovf_q, ovf_d;
  stc_res_t          res_q, res_d;

  logic                     accept;
  logic                     is_digit, is_upper, is_lower, keep;
  logic [7:0]               folded;
  logic [IDX_W-1:0]         sq, cnt_x, cnt1_x, idx_plus_c, idx_plus_1, col_start;
  logic [SIDE_W-1:0]        rows;
  logic [SIDE_W:0]          minor_p1, major_p1;
  logic                     row_done, col_last, idx_in;
  logic [SIDE_W+SIDE_LEN_W-1:0] side_pad;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign is_digit = (data_byte_i >= 8'h30) && (data_byte_i <= 8'h39);
  assign is_upper = (data_byte_i >= 8'h41) && (data_byte_i <= 8'h5A);
  assign is_lower = (data_byte_i >= 8'h61) && (data_byte_i <= 8'h7A);
  assign keep     = is_digit || is_upper || is_lower;
  assign folded   = is_upper ? (data_byte_i | 8'h20) : data_byte_i;

  assign sq         = {{SIDE_W{1'b0}}, side_q} * {{SIDE_W{1'b0}}, side_q};
  assign cnt_x      = IDX_W'(count_q);
  assign cnt1_x     = cnt_x + IDX_W'(1);
  assign idx_plus_c = idx_q + IDX_W'(side_q);
  assign idx_plus_1 = idx_q + IDX_W'(1);
  assign minor_p1   = {1'b0, minor_q} + (SIDE_W+1)'(1);
  assign major_p1   = {1'b0, major_q} + (SIDE_W+1)'(1);
  assign col_start  = IDX_W'(major_p1);
  assign col_last   = (major_p1 == {1'b0, side_q});
  assign idx_in     = (idx_q < cnt_x);
  assign side_pad   = {{SIDE_LEN_W{1'b0}}, side_q};

  // Rows of the rectangle: c-1 when the message fits in c*(c-1) cells.
  always_comb begin
    if (count_q == '0) begin
      rows = '0;
    end else if (cnt_x <= (sq - IDX_W'(side_q))) begin
      rows = side_q - SIDE_W'(1);
    end else begin
      rows = side_q;
    end
  end

  assign row_done = (minor_p1 >= {1'b0, rows});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fmt_q   <= FMT_CIPHER;
      count_q <= '0;
      side_q  <= '0;
      major_q <= '0;
      minor_q <= '0;
      idx_q   <= '0;
      sep_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fmt_q   <= fmt_d;
      count_q <= count_d;
      side_q  <= side_d;
      major_q <= major_d;
      minor_q <= minor_d;
      idx_q   <= idx_d;
      sep_q   <= sep_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_comb begin
    state_d = state_q;
    fmt_d   = fmt_q;
    count_d = count_q;
    side_d  = side_q;
    major_d = major_q;
    minor_d = minor_q;
    idx_d   = idx_q;
    sep_d   = sep_q;
    ovf_d   = ovf_q;
    res_d   = res_q;
    mem_we_o = 1'b0;
    mem_re_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode_i)
            MODE_WRITE: begin
              major_d = '0;
              minor_d = '0;
              idx_d   = '0;
              sep_d   = 1'b0;
              if (keep) begin
                if (count_q >= CNT_W'(CAPACITY)) begin
                  ovf_d = 1'b1;
                end else begin
                  mem_we_o = 1'b1;
                  count_d  = count_q + CNT_W'(1);
                  if (sq < cnt1_x) begin
                    side_d = side_q + SIDE_W'(1);
                  end
                end
              end
            end
            MODE_CLEAR: begin
              count_d = '0;
              side_d  = '0;
              ovf_d   = 1'b0;
              major_d = '0;
              minor_d = '0;
              idx_d   = '0;
              sep_d   = 1'b0;
            end
            MODE_READ: begin
              state_d           = ST_FETCH;
              mem_re_o          = 1'b1;
              res_d.char_src    = SRC_ZERO;
              res_d.group_end   = 1'b0;
              res_d.last        = 1'b0;
              res_d.none_left   = 1'b0;
              res_d.side_length = side_pad[SIDE_LEN_W-1:0];
              res_d.overflowed  = ovf_q;
              priority if (count_q == '0) begin
                res_d.none_left = 1'b1;
              end else if (fmt_q == FMT_CIPHER) begin
                if ((major_q >= side_q) || !idx_in) begin
                  res_d.none_left = 1'b1;
                end else begin
                  res_d.char_src = SRC_MEM;
                  if (row_done || (idx_plus_c >= cnt_x)) begin
                    res_d.group_end = 1'b1;
                    res_d.last      = col_last;
                    minor_d         = '0;
                    major_d         = major_p1[SIDE_W-1:0];
                    idx_d           = col_start;
                  end else begin
                    minor_d = minor_p1[SIDE_W-1:0];
                    idx_d   = idx_plus_c;
                  end
                end
              end else if (fmt_q == FMT_GROUPED) begin
                if (sep_q) begin
                  res_d.char_src = SRC_SPACE;
                  sep_d          = 1'b0;
                end else if (major_q >= side_q) begin
                  res_d.none_left = 1'b1;
                end else begin
                  res_d.char_src = idx_in ? SRC_MEM : SRC_SPACE;
                  if (row_done) begin
                    res_d.group_end = 1'b1;
                    res_d.last      = col_last;
                    sep_d           = !col_last;
                    minor_d         = '0;
                    major_d         = major_p1[SIDE_W-1:0];
                    idx_d           = col_start;
                  end else begin
                    minor_d = minor_p1[SIDE_W-1:0];
                    idx_d   = idx_plus_c;
                  end
                end
              end else if (fmt_q == FMT_ROWS) begin
                if ((major_q >= rows) || !idx_in) begin
                  res_d.none_left = 1'b1;
                end else begin
                  res_d.char_src = SRC_MEM;
                  if (idx_plus_1 == cnt_x) begin
                    res_d.group_end = 1'b1;
                    res_d.last      = 1'b1;
                  end else if (minor_p1 == {1'b0, side_q}) begin
                    res_d.group_end = 1'b1;
                  end
                  idx_d = idx_plus_1;
                  if (minor_p1 >= {1'b0, side_q}) begin
                    minor_d = '0;
                    major_d = major_p1[SIDE_W-1:0];
                  end else begin
                    minor_d = minor_p1[SIDE_W-1:0];
                  end
                end
              end else begin
                res_d.none_left = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FETCH: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Users change the format only while idle; not enforced. A change restarts the cursor.
    if (cfg_we_i) begin
      fmt_d   = cfg_wdata_i;
      major_d = '0;
      minor_d = '0;
      idx_d   = '0;
      sep_d   = 1'b0;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_FETCH);
  assign res_o       = res_q;
  assign mem_waddr_o = count_q[AW-1:0];
  assign mem_wdata_o = folded;
  assign mem_raddr_o = idx_q[AW-1:0];

  `STC_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(CAPACITY),
              "char count past capacity")
  `STC_ASSERT(a_side_covers, clk_i, rst_ni, sq >= cnt_x, "side squared below char count")
  `STC_ASSERT(a_side_empty, clk_i, rst_ni, (count_q == '0) |-> (side_q == '0),
              "side set on empty store")
  `STC_ASSERT(a_read_fetch, clk_i, rst_ni,
              (accept && (mode_i == MODE_READ)) |=> (state_q == ST_FETCH),
              "read did not start fetch")

endmodule

FILE: tb/square_transposition_cipher_tb.sv
// Testbench of the square transposition cipher: directed and random item streams with
// random idling on both channels, every result checked against a behavioral predictor.
// Depends on stc_pkg and the square_transposition_cipher RTL.
module square_transposition_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stc_pkg::*;

  // Store depth of the instance; the predictor keeps a store of the same size.
  localparam int unsigned STORE_DEPTH = 1024;
  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 2000;
  // Only this many mismatch lines are printed; all of them are counted.
  localparam int unsigned MAX_REPORTED = 100;
  // Codes that the package leaves unassigned but the fields can carry.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] FMT_UNUSED  = 2'd3;
  // Number of random items, not counting ignored ones.
  localparam int unsigned RANDOM_ITEMS = 450;

  // One result item as the block presents it.
  typedef struct packed {
    logic [7:0] ch;
    logic       group_end;
    logic       last;
    logic       none_left;
    logic [5:0] side;
    logic       overflowed;
  } cipher_char_t;

  logic       clk_i              = 1'b0;
  logic       rst_ni             = 1'b0;
  logic       output_format_we_i = 1'b0;
  logic [1:0] output_format_i    = FMT_CIPHER;
  logic       in_valid_i         = 1'b0;
  logic       in_stall_o;
  logic [1:0] mode_i             = MODE_READ;
  logic [7:0] data_byte_i        = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i        = 1'b0;
  logic [7:0] out_char_o;
  logic       group_end_o;
  logic       last_o;
  logic       none_left_o;
  logic [5:0] side_length_o;
  logic       overflowed_o;

  square_transposition_cipher #(
    .CAPACITY(STORE_DEPTH)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .output_format_we_i(output_format_we_i),
    .output_format_i   (output_format_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .mode_i            (mode_i),
    .data_byte_i       (data_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_char_o        (out_char_o),
    .group_end_o       (group_end_o),
    .last_o            (last_o),
    .none_left_o       (none_left_o),
    .side_length_o     (side_length_o),
    .overflowed_o      (overflowed_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------------------
  // Predictor state. It mirrors the block: the kept characters, their count, the square
  // side, the read cursor (column and row for the cipher formats, row and column for the
  // plain-text format), the pending separator of the grouped format and the drop flag.
  // ---------------------------------------------------------------------------------------
  logic [7:0]   msg_store [STORE_DEPTH];
  int unsigned  msg_len;
  int unsigned  side_c;
  int unsigned  cur_major;
  int unsigned  cur_minor;
  bit           space_due;
  bit           chars_dropped;
  logic [1:0]   out_format = FMT_CIPHER;

  // Characters that read items have asked for and that have not come out yet, oldest first.
  cipher_char_t pending_chars [$];
  int unsigned  mismatch_count;

  // Test control shared with the receiver: burst_mode turns idling off on both sides,
  // hold_cycles makes the receiver stall for that many cycles.
  bit           burst_mode;
  int unsigned  hold_cycles;

  function automatic void rewind_cursor();
    cur_major = 0;
    cur_minor = 0;
    space_due = 1'b0;
  endfunction

  function automatic void wipe_message();
    msg_len       = 0;
    side_c        = 0;
    chars_dropped = 1'b0;
    rewind_cursor();
  endfunction

  // A write restarts the cursor whether or not the byte is kept. Letters and digits are
  // kept, upper case folded to lower; a kept byte that finds the store full is dropped.
  function automatic void absorb_byte(logic [7:0] b);
    logic [7:0] folded;
    bit         keep;
    folded = b;
    keep   = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A);
    if (b >= 8'h41 && b <= 8'h5A) begin
      keep   = 1'b1;
      folded = b + 8'h20;
    end
    rewind_cursor();
    if (!keep) return;
    if (msg_len >= STORE_DEPTH) begin
      chars_dropped = 1'b1;
      return;
    end
    msg_store[msg_len] = folded;
    msg_len++;
    // The side grows by at most one per kept character.
    if (side_c * side_c < msg_len) side_c++;
  endfunction

  // Works out the character that the next read item returns and moves the cursor.
  function automatic cipher_char_t next_output();
    cipher_char_t res;
    int unsigned  rows;
    int unsigned  pos;
    int unsigned  nxt;
    res  = '0;
    rows = 0;
    if (msg_len != 0) rows = (msg_len <= side_c * (side_c - 1)) ? side_c - 1 : side_c;
    if (msg_len == 0) begin
      res.none_left = 1'b1;
    end else begin
      case (out_format)
        FMT_CIPHER: begin
          // Column by column; cells past the end of the message are skipped.
          pos = cur_minor * side_c + cur_major;
          if (cur_major >= side_c || pos >= msg_len) begin
            res.none_left = 1'b1;
          end else begin
            nxt    = cur_minor + 1;
            res.ch = msg_store[pos];
            if (nxt >= rows || nxt * side_c + cur_major >= msg_len) begin
              res.group_end = 1'b1;
              res.last      = (cur_major == side_c - 1);
              cur_minor     = 0;
              cur_major++;
            end else begin
              cur_minor = nxt;
            end
          end
        end
        FMT_GROUPED: begin
          // Every column is padded to the row count, and one space follows every column
          // group but the last one.
          if (space_due) begin
            res.ch    = SPACE_CHAR;
            space_due = 1'b0;
          end else if (cur_major >= side_c) begin
            res.none_left = 1'b1;
          end else begin
            pos    = cur_minor * side_c + cur_major;
            res.ch = (pos < msg_len) ? msg_store[pos] : SPACE_CHAR;
            if (cur_minor + 1 >= rows) begin
              res.group_end = 1'b1;
              if (cur_major == side_c - 1) res.last = 1'b1;
              else space_due = 1'b1;
              cur_minor = 0;
              cur_major++;
            end else begin
              cur_minor++;
            end
          end
        end
        FMT_ROWS: begin
          // Rows of side_c characters in message order; the last row may be short.
          pos = cur_major * side_c + cur_minor;
          if (cur_major >= rows || pos >= msg_len) begin
            res.none_left = 1'b1;
          end else begin
            res.ch        = msg_store[pos];
            res.last      = (pos == msg_len - 1);
            res.group_end = (pos == msg_len - 1) || (cur_minor == side_c - 1);
            if (cur_minor + 1 >= side_c) begin
              cur_minor = 0;
              cur_major++;
            end else begin
              cur_minor++;
            end
          end
        end
        default: begin
          // The unassigned format never yields a character.
          res.none_left = 1'b1;
        end
      endcase
    end
    res.side       = side_c[5:0];
    res.overflowed = chars_dropped;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTED) $display("%0t ns ERROR: %s", $time, msg);
  endtask

  task automatic compare_char(cipher_char_t want, cipher_char_t seen);
    if (seen.ch !== want.ch)
      report_mismatch($sformatf("out_char expected %h, got %h", want.ch, seen.ch));
    if (seen.group_end !== want.group_end)
      report_mismatch($sformatf("group_end expected %b, got %b", want.group_end,
                                seen.group_end));
    if (seen.last !== want.last)
      report_mismatch($sformatf("last expected %b, got %b", want.last, seen.last));
    if (seen.none_left !== want.none_left)
      report_mismatch($sformatf("none_left expected %b, got %b", want.none_left,
                                seen.none_left));
    if (seen.side !== want.side)
      report_mismatch($sformatf("side_length expected %0d, got %0d", want.side, seen.side));
    if (seen.overflowed !== want.overflowed)
      report_mismatch($sformatf("overflowed expected %b, got %b", want.overflowed,
                                seen.overflowed));
  endtask

  // Both channels are sampled right after the rising edge, which gives the values that the
  // block saw at that edge. Accepted input items advance the predictor; accepted results
  // are checked against the oldest pending character.
  always @(posedge clk_i) begin : track_items
    cipher_char_t seen;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        case (mode_i)
          MODE_WRITE: absorb_byte(data_byte_i);
          MODE_READ:  pending_chars.insert(pending_chars.size(), next_output());
          MODE_CLEAR: wipe_message();
          default:    ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        seen = '{out_char_o, group_end_o, last_o, none_left_o, side_length_o, overflowed_o};
        if (pending_chars.size() == 0)
          report_mismatch($sformatf("result %h with no read pending", seen.ch));
        else
          compare_char(pending_chars.pop_front(), seen);
      end
    end
  end

  // Ends a run that has stopped moving.
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet_cycles;
    if (!rst_ni || output_format_we_i || (in_valid_i && !in_stall_o) ||
        (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Receiver. After every accepted result it draws a number of stall cycles; a long hold
  // requested by a test takes precedence. The stall runs whether a result is waiting or
  // not, so it lands on every phase of a read.
  initial begin : receiver
    int unsigned wait_left;
    bit          stall_next;
    wait_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) wait_left = burst_mode ? 0 : $urandom_range(0, 7);
      if (hold_cycles > 0) begin
        hold_cycles--;
        stall_next = 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      out_stall_i <= stall_next;
    end
  end

  // Offers one item after a random gap and returns at the edge that accepts it. Valid stays
  // high into the next item when that one has no gap.
  task automatic send_item(logic [1:0] mode, logic [7:0] value);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    data_byte_i <= value;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stops offering items and waits until every read has produced its result; writes leave
  // nothing to wait for, so a closing wait lets the block finish them.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_format(logic [1:0] fmt);
    wait_idle();
    output_format_i    <= fmt;
    output_format_we_i <= 1'b1;
    @(posedge clk_i);
    output_format_we_i <= 1'b0;
    out_format = fmt;
    rewind_cursor();
  endtask

  function automatic logic [7:0] random_alnum();
    int unsigned pick;
    pick = $urandom_range(0, 61);
    if (pick < 10) return 8'h30 + pick[7:0];
    if (pick < 36) return 8'h41 + pick[7:0] - 8'd10;
    return 8'h61 + pick[7:0] - 8'd36;
  endfunction

  function automatic logic [1:0] random_format();
    if ($urandom_range(0, 9) == 0) return FMT_UNUSED;
    return 2'($urandom_range(0, 2));
  endfunction

  // Reads, a clear and an unassigned mode on a message that has nothing in it.
  task automatic test_empty_message();
    send_item(MODE_READ, 8'h00);
    send_item(MODE_CLEAR, 8'hFF);
    send_item(MODE_READ, 8'hFF);
    send_item(MODE_UNUSED, 8'hFF);
  endtask

  // The byte filter at each edge of the digit, upper and lower case ranges, then the same
  // short message in every format, a write between reads and the unassigned format.
  task automatic test_byte_filter();
    logic [7:0] probe [14];
    probe = '{8'h00, 8'h2F, 8'h30, 8'h39, 8'h3A, 8'h40, 8'h41,
              8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B, 8'hFF};
    foreach (probe[i]) send_item(MODE_WRITE, probe[i]);
    // Six kept characters: a side of three and two rows.
    repeat (7) send_item(MODE_READ, 8'h00);
    set_format(FMT_GROUPED);
    repeat (9) send_item(MODE_READ, 8'h00);
    set_format(FMT_ROWS);
    repeat (2) send_item(MODE_READ, 8'h00);
    // A dropped byte still sends the cursor back to the start.
    send_item(MODE_WRITE, 8'h23);
    repeat (2) send_item(MODE_READ, 8'h00);
    set_format(FMT_UNUSED);
    send_item(MODE_READ, 8'h00);
  endtask

  // Fills the store to the brim, drops further characters and checks that a clear lowers
  // the overflow flag again.
  task automatic test_store_overflow();
    set_format(FMT_ROWS);
    send_item(MODE_CLEAR, 8'h00);
    burst_mode = 1'b1;
    repeat (STORE_DEPTH + 2) send_item(MODE_WRITE, random_alnum());
    send_item(MODE_WRITE, 8'h2E);
    burst_mode = 1'b0;
    repeat (3) send_item(MODE_READ, 8'h00);
    set_format(FMT_CIPHER);
    repeat (3) send_item(MODE_READ, 8'h00);
    set_format(FMT_GROUPED);
    repeat (3) send_item(MODE_READ, 8'h00);
    send_item(MODE_CLEAR, 8'h00);
    send_item(MODE_READ, 8'h00);
  endtask

  // The receiver holds off for a long stretch while reads keep coming back to back, so the
  // output register and the control fill up and the input stalls.
  task automatic test_output_backpressure();
    set_format(FMT_GROUPED);
    send_item(MODE_CLEAR, 8'h00);
    repeat (16) send_item(MODE_WRITE, random_alnum());
    burst_mode  = 1'b1;
    hold_cycles = 150;
    repeat (25) send_item(MODE_READ, 8'h00);
    burst_mode = 1'b0;
  endtask

  // Random messages, mostly letters and digits with some noise bytes, each read out in
  // full and a little past its end. Now and then a format change, a write, a clear or an
  // unassigned mode cuts into the read-out.
  task automatic test_random_messages();
    int unsigned sent;
    int unsigned len;
    int unsigned side;
    int unsigned reads;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) set_format(random_format());
      send_item(MODE_CLEAR, 8'($urandom_range(0, 255)));
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 81) : $urandom_range(1, 24);
      for (int unsigned k = 0; k < len; k++) begin
        if ($urandom_range(0, 9) == 0) send_item(MODE_WRITE, 8'($urandom_range(0, 255)));
        else send_item(MODE_WRITE, random_alnum());
      end
      sent += len + 1;
      // Enough reads for the longest format, which adds padding and separators.
      side = 0;
      while (side * side < len) side++;
      reads = len + 2 * side + $urandom_range(0, 1);
      for (int unsigned k = 0; k < reads; k++) begin
        if (k == reads / 2 && $urandom_range(0, 4) == 0) set_format(random_format());
        case ($urandom_range(0, 79))
          0, 1: begin
            send_item(MODE_WRITE, 8'($urandom_range(0, 255)));
            sent++;
          end
          2: begin
            send_item(MODE_CLEAR, 8'($urandom_range(0, 255)));
            sent++;
          end
          3: send_item(MODE_UNUSED, 8'($urandom_range(0, 255)));
          default: ;
        endcase
        send_item(MODE_READ, 8'($urandom_range(0, 255)));
        sent++;
      end
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_message();
    test_byte_filter();
    test_store_overflow();
    test_output_backpressure();
    test_random_messages();
    wait_idle();
    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
